FILE: hw/rtl/itoa_pkg.sv
package itoa_pkg;

	localparam int ValueW        = 32;
	localparam int DigitW        = 4;
	localparam int NumDigits     = 10;
	localparam int BcdW          = DigitW * NumDigits;
	localparam int IdxW          = $clog2(NumDigits);
	localparam int StepsPerStage = 8;

	localparam logic [7:0] CharZero  = 8'd48;
	localparam logic [7:0] CharMinus = 8'd45;

	typedef struct packed {
		logic            neg;
		logic [BcdW-1:0] bcd;
	} conv_word_t;

	typedef struct packed {
		logic [BcdW-1:0]   bcd;
		logic [ValueW-1:0] bin;
	} dab_t;

	// eight shift-and-add-3 steps, MSB of bin first
	function automatic dab_t dabble8(input logic [BcdW-1:0] bcd_in,
		input logic [ValueW-1:0] bin_in);
		logic [BcdW-1:0]   b;
		logic [ValueW-1:0] v;
		dab_t              r;
		b = bcd_in;
		v = bin_in;
		for (int s = 0; s < StepsPerStage; s++) begin
			for (int d = 0; d < NumDigits; d++) begin
				if (b[d*DigitW +: DigitW] >= 4'd5) begin
					b[d*DigitW +: DigitW] = b[d*DigitW +: DigitW] + 4'd3;
				end
			end
			b = {b[BcdW-2:0], v[ValueW-1]};
			v = {v[ValueW-2:0], 1'b0};
		end
		r.bcd = b;
		r.bin = v;
		return r;
	endfunction

endpackage

FILE: hw/rtl/itoa_ser.sv
module itoa_ser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  itoa_pkg::conv_word_t in_word,
	output logic                strobe,
	output logic [7:0]          ascii_char,
	output logic                last
);
	import itoa_pkg::*;

	logic            active_q;
	logic            sign_q;
	logic [IdxW-1:0] idx_q;
	logic [BcdW-1:0] digits_q;
	logic [IdxW-1:0] top_idx;
	logic [DigitW-1:0] cur_digit;
	logic            load;

	// highest non-zero digit; zero gives a single '0'
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < NumDigits; i++) begin
			if (in_word.bcd[i*DigitW +: DigitW] != '0) begin
				top_idx = IdxW'(i);
			end
		end
	end

	assign in_ready  = !active_q || (!sign_q && idx_q == '0);
	assign load      = in_valid && in_ready;
	assign cur_digit = digits_q[idx_q*DigitW +: DigitW];

	assign strobe     = active_q;
	assign ascii_char = sign_q ? CharMinus : (CharZero + {4'b0000, cur_digit});
	assign last       = !sign_q && idx_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			sign_q   <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			active_q <= 1'b1;
			sign_q   <= in_word.neg;
			idx_q    <= top_idx;
		end else if (active_q) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else if (idx_q == '0) begin
				active_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digits_q <= in_word.bcd;
		end
	end

`ifndef SYNTHESIS
	a_sign_only_when_active: assert property (@(posedge clk) disable iff (!arst_n)
		sign_q |-> active_q) else $error("sign pending while idle");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> idx_q < IdxW'(NumDigits)) else $error("digit index out of range");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last && !in_valid |=> !strobe) else $error("word after last");
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ascii_char == CharMinus || (ascii_char >= CharZero && ascii_char <= 8'd57))
		else $error("illegal character");
`endif

endmodule

FILE: hw/rtl/integer_to_decimal_ascii_top.sv
// A started word passes registers s1 to s5 and is then loaded into the serialiser.
// Throughput: one character per cycle; an item of n characters (1..11) holds
// the output stream for its n characters, set by the single character serialiser.
// A four-stage double-dabble pipeline feeds it; items may enter every cycle
// while the stream keeps up. Reset clears all valid bits and the serialiser's state flags.
module integer_to_decimal_ascii_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        kind,
	input  logic [itoa_pkg::ValueW-1:0] value,
	output logic                        strobe,
	output logic [7:0]                  ascii_char,
	output logic                        last
);
	import itoa_pkg::*;

	logic              valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic              neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [ValueW-1:0] mag_s1, bin_s2, bin_s3, bin_s4;
	logic [BcdW-1:0]   bcd_s2, bcd_s3, bcd_s4, bcd_s5;
	logic              free1, free2, free3, free4, free5;
	logic              ser_ready;
	logic              accept;
	logic              neg_in;
	dab_t              dab2, dab3, dab4, dab5;
	conv_word_t        ser_word;

	assign free5 = !valid_s5 || ser_ready;
	assign free4 = !valid_s4 || free5;
	assign free3 = !valid_s3 || free4;
	assign free2 = !valid_s2 || free3;
	assign free1 = !valid_s1 || free2;

	assign busy   = !free1;
	assign accept = start && free1;
	assign neg_in = !kind && value[ValueW-1];

	assign dab2 = dabble8('0, mag_s1);
	assign dab3 = dabble8(bcd_s2, bin_s2);
	assign dab4 = dabble8(bcd_s3, bin_s3);
	assign dab5 = dabble8(bcd_s4, bin_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (free1) valid_s1 <= start;
			if (free2) valid_s2 <= valid_s1;
			if (free3) valid_s3 <= valid_s2;
			if (free4) valid_s4 <= valid_s3;
			if (free5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_s1 <= neg_in;
			mag_s1 <= neg_in ? (ValueW'(0) - value) : value;
		end
		if (free2 && valid_s1) begin
			neg_s2 <= neg_s1;
			bcd_s2 <= dab2.bcd;
			bin_s2 <= dab2.bin;
		end
		if (free3 && valid_s2) begin
			neg_s3 <= neg_s2;
			bcd_s3 <= dab3.bcd;
			bin_s3 <= dab3.bin;
		end
		if (free4 && valid_s3) begin
			neg_s4 <= neg_s3;
			bcd_s4 <= dab4.bcd;
			bin_s4 <= dab4.bin;
		end
		if (free5 && valid_s4) begin
			neg_s5 <= neg_s4;
			bcd_s5 <= dab5.bcd;
		end
	end

	assign ser_word.neg = neg_s5;
	assign ser_word.bcd = bcd_s5;

	itoa_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (valid_s5),
		.in_ready   (ser_ready),
		.in_word    (ser_word),
		.strobe     (strobe),
		.ascii_char (ascii_char),
		.last       (last)
	);

`ifndef SYNTHESIS
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> valid_s1) else $error("accepted word not in stage 1");
	a_busy_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5)
		else $error("busy with a free stage");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && !ser_ready |=> valid_s5 && $stable(bcd_s5) && $stable(neg_s5))
		else $error("stalled word changed");
`endif

endmodule
